@@ hw/rtl/sdr_pkg.sv @@
// ---------------------------------------------------------------------------
// sdr_pkg: shared definitions of the stream-aware replacement engine
// Sizes, RRPV and counter constants, register indexes and memory row types.
// ---------------------------------------------------------------------------
`default_nettype none
package sdr_pkg;
   localparam int SETS        = 2048;
   localparam int SET_BITS    = $clog2(SETS);
   localparam int WAYS        = 16;
   localparam int WAY_BITS    = $clog2(WAYS);
   localparam int SIG_BITS    = 6;
   localparam int CTRS        = 1 << SIG_BITS;
   localparam int PSEL_WIDTH  = 10;
   localparam int LEADER_SETS = 64;
   localparam int ADDR_BITS   = 48;
   localparam int STRIDE_BITS = ADDR_BITS + 1;
   localparam int LFSR_BITS   = 16;
   localparam int CLEAR_LEN   = (SETS > CTRS) ? SETS : CTRS;
   localparam int CLEAR_BITS  = $clog2(CLEAR_LEN);

   localparam logic [1:0] RRPV_MAX  = 2'd3;
   localparam logic [1:0] RRPV_LONG = 2'd2;
   localparam logic [1:0] RRPV_NEAR = 2'd0;
   localparam logic [1:0] CTR_MAX   = 2'd3;
   localparam logic [1:0] CONF_MAX  = 2'd3;

   localparam logic [PSEL_WIDTH-1:0] PSEL_MID = PSEL_WIDTH'(1 << (PSEL_WIDTH - 1));
   localparam logic [PSEL_WIDTH-1:0] PSEL_TOP = {PSEL_WIDTH{1'b1}};
   localparam logic [LFSR_BITS-1:0]  LFSR_SEED = 16'hACE1;

   // Register indexes of the configuration port.
   localparam logic CSR_STREAM_THRESHOLD = 1'b0;
   localparam logic CSR_BRRIP_RARITY     = 1'b1;

   typedef struct packed {
      logic [WAYS-1:0][1:0]          rrpv;
      logic [WAYS-1:0][SIG_BITS-1:0] sig;
      logic [ADDR_BITS-1:0]          seen_addr;
      logic [STRIDE_BITS-1:0]        last_stride;
      logic [1:0]                    conf;
   } set_row_type;

   typedef struct packed {
      logic                en;
      logic [SET_BITS-1:0] addr;
      set_row_type         data;
   } row_wr_type;

   typedef struct packed {
      logic                en;
      logic [SIG_BITS-1:0] addr;
      logic [1:0]          data;
   } ctr_wr_type;
endpackage
`default_nettype wire

@@ hw/rtl/sdr_set_store.sv @@
// ---------------------------------------------------------------------------
// sdr_set_store: per-set state memory
// One row per set holds all RRPVs, signatures and the stream detector.
// ---------------------------------------------------------------------------
`default_nettype none
module sdr_set_store
   import sdr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                rd_en,
   input  wire logic [SET_BITS-1:0] rd_addr,
   input  wire row_wr_type          wr,
   output set_row_type              rd_data
);
   set_row_type mem [SETS];
   set_row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
      if (wr.en) mem[wr.addr] <= wr.data;
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

@@ hw/rtl/sdr_ctr_table.sv @@
// ---------------------------------------------------------------------------
// sdr_ctr_table: signature outcome counters
// Two registered read ports and one write port over the 2-bit counters.
// ---------------------------------------------------------------------------
`default_nettype none
module sdr_ctr_table
   import sdr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                rd_a_en,
   input  wire logic [SIG_BITS-1:0] rd_a_addr,
   input  wire logic                rd_b_en,
   input  wire logic [SIG_BITS-1:0] rd_b_addr,
   input  wire ctr_wr_type          wr,
   output logic [1:0]               rd_a_data,
   output logic [1:0]               rd_b_data
);
   logic [1:0] mem [CTRS];
   logic [1:0] rd_a_ff;
   logic [1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (rd_a_en) rd_a_ff <= mem[rd_a_addr];
      if (rd_b_en) rd_b_ff <= mem[rd_b_addr];
      if (wr.en) mem[wr.addr] <= wr.data;
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;
endmodule
`default_nettype wire

@@ hw/rtl/ship_drrip_stream_replacement_top.sv @@
// ---------------------------------------------------------------------------
// ship_drrip_stream_replacement_top: last-level-cache replacement engine
//
// Requests arrive on the req_ channel. Mode 0 asks for a victim way of a
// set (the set is aged so that one way reaches RRPV 3); mode 1 reports an
// access, trains the stride detector, and promotes or inserts the block.
// Each request gives one transfer on the rsp_ channel: the way, and the
// RRPV written (zero for victim requests and hits).
// A victim request reads the set row and writes it back aged; an update
// reads the set row and then the counter of the evicted signature, and
// writes both back. Requests are handled one at a time, so a new one is
// taken only after the last has completed. The result waits in an output
// register while rsp_stall is high, and the next request may be taken
// meanwhile; its completion waits for that register to drain.
// After reset a clearing pass writes every set row and every counter,
// one per cycle; req_stall stays high throughout, while configuration
// writes on csr_ are taken at any time.
// ---------------------------------------------------------------------------
`default_nettype none
module ship_drrip_stream_replacement_top
   import sdr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_mode,
   input  wire logic [10:0] req_set_index,
   input  wire logic [3:0]  req_way_index,
   input  wire logic [47:0] req_phys_addr,
   input  wire logic [63:0] req_pc,
   input  wire logic        req_hit,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_victim_way,
   output logic [1:0]       rsp_inserted_rrpv,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_addr,
   input  wire logic [3:0]  csr_wr_data
);
   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_UPD   = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [CLEAR_BITS-1:0] clr_ff, clr_in;
   logic [1:0]            thr_ff, thr_in;
   logic [3:0]            rar_ff, rar_in;
   logic [PSEL_WIDTH-1:0] psel_ff, psel_in;
   logic [LFSR_BITS-1:0]  lfsr_ff, lfsr_in;
   logic                  mode_ff, mode_in;
   logic [SET_BITS-1:0]   set_ff, set_in;
   logic [WAY_BITS-1:0]   way_ff, way_in;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [SIG_BITS-1:0]   sig_ff, sig_in;
   logic                  hit_ff, hit_in;
   logic [SIG_BITS-1:0]   old_ff, old_in;
   logic                  strm_ff, strm_in;
   logic [STRIDE_BITS-1:0] stride_ff, stride_in;
   logic [1:0]            conf_ff, conf_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WAY_BITS-1:0]   rsp_way_ff, rsp_way_in;
   logic [1:0]            rsp_ins_ff, rsp_ins_in;

   logic                  req_xfer;
   logic                  out_free;
   set_row_type           row;
   set_row_type           row_new;
   row_wr_type            row_wr;
   ctr_wr_type            ctr_wr;
   logic                  ctr_b_en;
   logic [1:0]            ctr_sig_rd;
   logic [1:0]            ctr_old_rd;
   logic                  any3, any2, any1;
   logic [1:0]            top_rrpv;
   logic [1:0]            gap;
   logic [WAY_BITS-1:0]   vict;
   logic [STRIDE_BITS-1:0] stride;
   logic                  stride_match;
   logic [1:0]            conf_next;
   logic [1:0]            ctr_w;
   logic [1:0]            ctr_s;
   logic                  srrip_lead, brrip_lead, bimodal_pick;
   logic [LFSR_BITS-1:0]  lfsr_next;
   logic [LFSR_BITS-1:0]  rar_mask;
   logic [1:0]            ins;
   logic                  step_lfsr;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   sdr_set_store u_set (
      .clock   (clock),
      .rd_en   (req_xfer),
      .rd_addr (req_set_index[SET_BITS-1:0]),
      .wr      (row_wr),
      .rd_data (row)
   );

   sdr_ctr_table u_ctr (
      .clock     (clock),
      .rd_a_en   (req_xfer),
      .rd_a_addr (req_pc[2 +: SIG_BITS]),
      .rd_b_en   (ctr_b_en),
      .rd_b_addr (old_in),
      .wr        (ctr_wr),
      .rd_a_data (ctr_sig_rd),
      .rd_b_data (ctr_old_rd)
   );

   // Set row analysis: ageing for victim search, stride training.
   always_comb begin
      any3 = 1'b0;
      any2 = 1'b0;
      any1 = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         any3 = any3 | (row.rrpv[w] == 2'd3);
         any2 = any2 | (row.rrpv[w] == 2'd2);
         any1 = any1 | (row.rrpv[w] == 2'd1);
      end
      top_rrpv = any3 ? 2'd3 : any2 ? 2'd2 : any1 ? 2'd1 : 2'd0;
      gap      = RRPV_MAX - top_rrpv;
      vict     = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (row.rrpv[w] == top_rrpv) vict = WAY_BITS'(w);
      end
      stride       = {1'b0, addr_ff} - {1'b0, row.seen_addr};
      stride_match = (row.seen_addr != '0) && (stride == row.last_stride);
      if (stride_match) conf_next = (row.conf == CONF_MAX) ? row.conf : row.conf + 2'd1;
      else              conf_next = (row.conf == 2'd0) ? row.conf : row.conf - 2'd1;
   end

   // Insertion decision on the counters read back.
   always_comb begin
      srrip_lead   = (32'(set_ff) < LEADER_SETS);
      brrip_lead   = !srrip_lead && (32'(set_ff) < 2 * LEADER_SETS);
      bimodal_pick = srrip_lead ? 1'b0 : brrip_lead ? 1'b1 : (psel_ff >= PSEL_MID);
      lfsr_next  = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5], lfsr_ff[LFSR_BITS-1:1]};
      rar_mask   = ~({LFSR_BITS{1'b1}} << rar_ff);
      step_lfsr  = 1'b0;
      if (hit_ff) begin
         ctr_w = (ctr_old_rd == CTR_MAX) ? ctr_old_rd : ctr_old_rd + 2'd1;
      end else begin
         ctr_w = (ctr_old_rd == 2'd0) ? ctr_old_rd : ctr_old_rd - 2'd1;
      end
      // The penalty lands first, so a refill by the same signature sees it.
      ctr_s = (old_ff == sig_ff) ? ctr_w : ctr_sig_rd;
      if (hit_ff)                 ins = RRPV_NEAR;
      else if (strm_ff)           ins = RRPV_MAX;
      else if (ctr_s == 2'd0)     ins = RRPV_MAX;
      else if (ctr_s == CTR_MAX)  ins = RRPV_NEAR;
      else if (bimodal_pick) begin
         step_lfsr = 1'b1;
         ins = ((lfsr_next & rar_mask) == '0) ? RRPV_LONG : RRPV_MAX;
      end else                    ins = RRPV_LONG;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      thr_in       = thr_ff;
      rar_in       = rar_ff;
      psel_in      = psel_ff;
      lfsr_in      = lfsr_ff;
      mode_in      = mode_ff;
      set_in       = set_ff;
      way_in       = way_ff;
      addr_in      = addr_ff;
      sig_in       = sig_ff;
      hit_in       = hit_ff;
      old_in       = old_ff;
      strm_in      = strm_ff;
      stride_in    = stride_ff;
      conf_in      = conf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_way_in   = rsp_way_ff;
      rsp_ins_in   = rsp_ins_ff;
      ctr_b_en     = 1'b0;
      row_new      = row;
      row_wr       = '0;
      ctr_wr       = '0;

      if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_STREAM_THRESHOLD: thr_in = csr_wr_data[1:0];
            CSR_BRRIP_RARITY:     rar_in = csr_wr_data;
            default:              ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            row_wr.en   = (32'(clr_ff) < SETS);
            row_wr.addr = clr_ff[SET_BITS-1:0];
            for (int w = 0; w < WAYS; w++) row_wr.data.rrpv[w] = RRPV_LONG;
            ctr_wr.en   = (32'(clr_ff) < CTRS);
            ctr_wr.addr = clr_ff[SIG_BITS-1:0];
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == CLEAR_BITS'(CLEAR_LEN - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_xfer) begin
               mode_in  = req_mode;
               set_in   = req_set_index[SET_BITS-1:0];
               way_in   = req_way_index[WAY_BITS-1:0];
               addr_in  = req_phys_addr[ADDR_BITS-1:0];
               sig_in   = req_pc[2 +: SIG_BITS];
               hit_in   = req_hit;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (!mode_ff) begin
               if (out_free) begin
                  for (int w = 0; w < WAYS; w++) row_new.rrpv[w] = row.rrpv[w] + gap;
                  row_wr.en    = 1'b1;
                  row_wr.addr  = set_ff;
                  row_wr.data  = row_new;
                  rsp_valid_in = 1'b1;
                  rsp_way_in   = vict;
                  rsp_ins_in   = RRPV_NEAR;
                  state_in     = ST_IDLE;
               end
            end else begin
               old_in    = row.sig[way_ff];
               ctr_b_en  = 1'b1;
               stride_in = stride;
               conf_in   = conf_next;
               strm_in   = (conf_next >= thr_ff);
               state_in  = ST_UPD;
            end
         end
         ST_UPD: begin
            if (out_free) begin
               row_new.rrpv[way_ff] = ins;
               if (!hit_ff) row_new.sig[way_ff] = sig_ff;
               row_new.seen_addr   = addr_ff;
               row_new.last_stride = stride_ff;
               row_new.conf        = conf_ff;
               row_wr.en    = 1'b1;
               row_wr.addr  = set_ff;
               row_wr.data  = row_new;
               ctr_wr.en    = 1'b1;
               ctr_wr.addr  = old_ff;
               ctr_wr.data  = ctr_w;
               if (step_lfsr) lfsr_in = lfsr_next;
               if (!hit_ff) begin
                  if (srrip_lead && ins == RRPV_LONG && psel_ff != PSEL_TOP)
                     psel_in = psel_ff + 1'b1;
                  else if (brrip_lead && ins == RRPV_MAX && psel_ff != '0)
                     psel_in = psel_ff - 1'b1;
               end
               rsp_valid_in = 1'b1;
               rsp_way_in   = way_ff;
               rsp_ins_in   = ins;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         thr_ff       <= 2'd3;
         rar_ff       <= 4'd5;
         psel_ff      <= PSEL_MID;
         lfsr_ff      <= LFSR_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         thr_ff       <= thr_in;
         rar_ff       <= rar_in;
         psel_ff      <= psel_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff    <= mode_in;
      set_ff     <= set_in;
      way_ff     <= way_in;
      addr_ff    <= addr_in;
      sig_ff     <= sig_in;
      hit_ff     <= hit_in;
      old_ff     <= old_in;
      strm_ff    <= strm_in;
      stride_ff  <= stride_in;
      conf_ff    <= conf_in;
      rsp_way_ff <= rsp_way_in;
      rsp_ins_ff <= rsp_ins_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_victim_way    = 4'(rsp_way_ff);
   assign rsp_inserted_rrpv = rsp_ins_ff;
endmodule
`default_nettype wire

@@ hw/rtl/sdr_checker.sv @@
// ---------------------------------------------------------------------------
// sdr_checker: port-level checks of the replacement engine
// Watches the request and response channels of the top level.
// ---------------------------------------------------------------------------
`default_nettype none
module sdr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [3:0] rsp_victim_way,
   input wire logic [1:0] rsp_inserted_rrpv
);
   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Requests are worked on one at a time: a transfer closes the input.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while busy");

   // Unless a stalled result is still held, no result appears in the cycle right after a request transfer.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !(rsp_valid && rsp_stall)) |=> !rsp_valid)
      else $error("response too early");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_victim_way)
                                    && $stable(rsp_inserted_rrpv)))
      else $error("stalled response changed");
endmodule

bind ship_drrip_stream_replacement_top sdr_checker u_sdr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_victim_way    (rsp_victim_way),
   .rsp_inserted_rrpv (rsp_inserted_rrpv)
);
`default_nettype wire
